/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Types shared by the controller and the datapath of the running median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    typedef enum logic [9:0] {
        S_CLR  = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_RING = 10'b00_0000_0100,
        S_DRD  = 10'b00_0000_1000,
        S_DWR  = 10'b00_0001_0000,
        S_IRD  = 10'b00_0010_0000,
        S_IWR  = 10'b00_0100_0000,
        S_ARD  = 10'b00_1000_0000,
        S_AEV  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic clr;
        logic cfg_wr;
        logic accept;
        logic ring;
        logic dec_rd;
        logic dec_wr;
        logic inc_rd;
        logic inc_wr;
        logic adj_rd;
        logic adj_ev;
        logic sel_up;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic full;
        logic adj_more;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: length writes, histogram clear pass, window update, pointer walk and result hand-off.
// ----------------------------------------------------------------------------
module swm_ctrl import swm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_cfg_valid,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_idle
);

    t_state r_state, n_state;
    logic   r_sel_up, n_sel_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_sel_up <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel_up <= n_sel_up;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_sel_up = r_sel_up;
        o_cmd    = '0;
        o_cmd.sel_up = r_sel_up;
        o_idle   = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_cfg_valid) begin
                    o_cmd.cfg_wr = 1'b1;
                    n_state = S_CLR;
                end else if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_RING;
                end
            end
            S_RING: begin
                o_cmd.ring = 1'b1;
                n_state = S_DRD;
            end
            S_DRD: begin
                o_cmd.dec_rd = 1'b1;
                n_state = S_DWR;
            end
            S_DWR: begin
                o_cmd.dec_wr = 1'b1;
                n_state = S_IRD;
            end
            S_IRD: begin
                o_cmd.inc_rd = 1'b1;
                n_state = S_IWR;
            end
            S_IWR: begin
                o_cmd.inc_wr = 1'b1;
                n_sel_up = 1'b0;
                n_state = i_st.full ? S_ARD : S_IDLE;
            end
            S_ARD: begin
                o_cmd.adj_rd = 1'b1;
                n_state = S_AEV;
            end
            S_AEV: begin
                o_cmd.adj_ev = 1'b1;
                if (i_st.adj_more) begin
                    n_state = S_ARD;
                end else if (!r_sel_up) begin
                    n_sel_up = 1'b1;
                    n_state = S_ARD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

/* hw/rtl/swm_dp.sv */
// ----------------------------------------------------------------------------
// swm_dp
// Sample ring, value histogram, median pointers with their ranks, result word.
// ----------------------------------------------------------------------------
module swm_dp import swm_pkg::*; #(
    parameter int WINDOW_MAX = 256,
    parameter int VALUE_BINS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_st,
    input  logic [8:0]  i_cfg_data,
    input  logic [9:0]  i_sample,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [10:0] o_median_twice
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int VW = $clog2(VALUE_BINS);
    localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [CW-1:0] r_len, r_fill, r_lc, r_uc;
    logic [RW-1:0] r_idx;
    logic [VW-1:0] r_s, r_old, r_lp, r_up, r_clr;
    logic          r_evict, r_dir, r_valid;
    logic [10:0]   r_med;

    logic [VW-1:0] r_ring [WINDOW_MAX];
    logic [CW-1:0] r_hist [VALUE_BINS];
    logic [CW-1:0] r_rd;

    logic [31:0]   cfg_ext, len_sat, s_ext, s_sat;
    logic [CW-1:0] k_lo, k_hi, k_sel, c_sel;
    logic [VW-1:0] p_sel;
    logic          up_now, dn_ok;
    logic [VW-1:0] h_ra, h_wa;
    logic [CW-1:0] h_wd;
    logic          h_we;
    logic [VW:0]   sum;

    always_comb begin
        cfg_ext = {23'd0, i_cfg_data};
        if (cfg_ext == 32'd0) len_sat = 32'd1;
        else if (cfg_ext > 32'(WINDOW_MAX)) len_sat = 32'(WINDOW_MAX);
        else len_sat = cfg_ext;
        s_ext = {22'd0, i_sample};
        s_sat = (s_ext >= 32'(VALUE_BINS)) ? 32'(VALUE_BINS - 1) : s_ext;
    end

    assign k_lo  = CW'((32'(r_len) + 32'd1) >> 1);
    assign k_hi  = CW'((32'(r_len) >> 1) + 32'd1);
    assign k_sel = i_cmd.sel_up ? k_hi : k_lo;
    assign c_sel = i_cmd.sel_up ? r_uc : r_lc;
    assign p_sel = i_cmd.sel_up ? r_up : r_lp;
    assign up_now = c_sel < k_sel;
    // step down while the bins below the pointer still reach the rank
    assign dn_ok = (p_sel != '0) &&
                   ({1'b0, c_sel} >= ({1'b0, r_rd} + {1'b0, k_sel}));

    always_comb begin
        h_ra = r_s;
        h_we = 1'b0;
        h_wa = r_s;
        h_wd = r_rd + CW'(1);
        if (i_cmd.dec_rd) h_ra = r_old;
        else if (i_cmd.adj_rd) h_ra = up_now ? p_sel + VW'(1) : p_sel;
        if (i_cmd.clr) begin
            h_we = 1'b1;
            h_wa = r_clr;
            h_wd = '0;
        end else if (i_cmd.dec_wr) begin
            h_we = r_evict && (r_rd != '0);
            h_wa = r_old;
            h_wd = r_rd - CW'(1);
        end else if (i_cmd.inc_wr) begin
            h_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) r_hist[h_wa] <= h_wd;
        r_rd <= r_hist[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring) begin
            r_old <= r_ring[r_idx];
            r_ring[r_idx] <= r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_s <= VW'(s_sat);
        if (i_cmd.ring) r_evict <= (r_fill >= r_len);
        if (i_cmd.adj_rd) r_dir <= up_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CW'(1);
            r_fill <= '0;
            r_idx <= '0;
            r_lp <= '0;
            r_up <= '0;
            r_lc <= '0;
            r_uc <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_len <= CW'(len_sat);
                r_fill <= '0;
                r_idx <= '0;
                r_lp <= '0;
                r_up <= '0;
                r_lc <= '0;
                r_uc <= '0;
                r_clr <= '0;
            end
            if (i_cmd.clr) r_clr <= r_clr + VW'(1);
            if (i_cmd.ring) begin
                if (r_fill < r_len) r_fill <= r_fill + CW'(1);
                if (32'(r_idx) + 32'd1 >= 32'(r_len)) r_idx <= '0;
                else r_idx <= r_idx + RW'(1);
            end
            if (i_cmd.dec_wr && r_evict && (r_rd != '0)) begin
                if (r_old <= r_lp) r_lc <= r_lc - CW'(1);
                if (r_old <= r_up) r_uc <= r_uc - CW'(1);
            end
            if (i_cmd.inc_wr) begin
                if (r_s <= r_lp) r_lc <= r_lc + CW'(1);
                if (r_s <= r_up) r_uc <= r_uc + CW'(1);
            end
            if (i_cmd.adj_ev) begin
                if (r_dir) begin
                    if (i_cmd.sel_up) begin
                        r_up <= r_up + VW'(1);
                        r_uc <= r_uc + r_rd;
                    end else begin
                        r_lp <= r_lp + VW'(1);
                        r_lc <= r_lc + r_rd;
                    end
                end else if (dn_ok) begin
                    if (i_cmd.sel_up) begin
                        r_up <= r_up - VW'(1);
                        r_uc <= r_uc - r_rd;
                    end else begin
                        r_lp <= r_lp - VW'(1);
                        r_lc <= r_lc - r_rd;
                    end
                end
            end
        end
    end

    assign sum = {1'b0, r_lp} + {1'b0, r_up};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_cmd.out_load) r_med <= 11'(32'(sum));
    end

    assign o_st.clr_last = (r_clr == VW'(VALUE_BINS - 1));
    assign o_st.full     = (r_fill >= r_len);
    assign o_st.adj_more = r_dir || dn_ok;
    assign o_st.out_free = !r_valid || i_ready;

    assign o_valid        = r_valid;
    assign o_median_twice = r_med;

endmodule

/* hw/rtl/sliding_window_median_unit.sv */
// Running median of the last window_len samples (1 to WINDOW_MAX), given as
// twice the median once the window is full; no word comes out while it
// fills. A sample is accepted and stored in the ring, then any evicted
// value's bin is read and decremented and the new value's bin read and
// incremented; each of the two median pointers then walks one histogram bin
// per read and evaluate step plus a final step to confirm its place, and the
// result goes to the output register once that register is free; the single
// histogram read port serialises these steps. After reset and after every
// window_len write, all VALUE_BINS bins are cleared before a sample is taken.
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Top level: histogram based running median filter.
// ----------------------------------------------------------------------------
module sliding_window_median_unit import swm_pkg::*; #(
    parameter int WINDOW_MAX = 256,
    parameter int VALUE_BINS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [9:0]  i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_median_twice,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    t_cmd    cmd;
    t_status st;
    logic    idle;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_idle      (idle)
    );

    swm_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .VALUE_BINS (VALUE_BINS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_median_twice (o_median_twice)
    );

    // a length write wins over a sample word in the same cycle
    assign o_ready     = idle && !i_cfg_valid;
    assign o_cfg_ready = idle;

endmodule

/* hw/rtl/swm_checker.sv */
// ----------------------------------------------------------------------------
// swm_checker
// Port level checks on the running median unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [9:0]  i_sample,
    input logic        o_valid,
    input logic        i_ready,
    input logic [10:0] o_median_twice,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [8:0]  i_cfg_data
);

    `SWM_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result word dropped")
    `SWM_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_median_twice), "result word changed while stalled")
    `SWM_ASSERT(a_busy, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready && !o_cfg_ready, "ready right after taking a word")
    `SWM_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid && !o_ready && !o_cfg_ready, "not quiet after reset")

endmodule

bind sliding_window_median_unit swm_checker u_swm_checker (.*);
